@@ hw/rtl/lcbr_pkg.sv @@
`default_nettype none

package lcbr_pkg;

    // Print line geometry
    localparam int LINE_DOTS        = 384;
    localparam int BAND_ROWS        = 8;
    localparam int ROW_BYTES        = (LINE_DOTS + 7) / 8;
    localparam int BANKS            = 2;
    localparam int BANK_DEPTH       = (ROW_BYTES + BANKS - 1) / BANKS;
    localparam int BANK_AW          = $clog2(BANK_DEPTH);
    localparam int WORD_W           = BAND_ROWS * 8;
    localparam int POS_W            = 12;

    // Logo and counter limits
    localparam int MAX_LOGO_COLUMNS = 576;
    localparam int COUNT_W          = 10;
    localparam int COUNT_MAX        = (1 << COUNT_W) - 1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PLACE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_MIDDLE = 2'd1,
        ALIGN_RIGHT  = 2'd2
    } align_t;

    typedef enum logic [1:0] {
        REG_ALIGN_MODE   = 2'd0,
        REG_LOGO_COLUMNS = 2'd1,
        REG_DOUBLE_WIDTH = 2'd2
    } cfg_reg_t;

    // One bank's share of a beat: which band word, which dots of its byte
    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [7:0]         mask;
    } plan_t;

endpackage

`default_nettype wire

@@ hw/rtl/lcbr_ram.sv @@
`default_nettype none

module lcbr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lcbr_place.sv @@
`default_nettype none

module lcbr_place (
    input  wire logic [lcbr_pkg::COUNT_W-1:0] count,
    input  wire logic [1:0]                   align_mode,
    input  wire logic [9:0]                   logo_columns,
    input  wire logic                         double_width,
    output lcbr_pkg::plan_t                   plan_even,
    output lcbr_pkg::plan_t                   plan_odd
);

    import lcbr_pkg::*;

    logic [9:0]         w;
    logic [10:0]        m;
    logic [10:0]        line_m;
    logic [10:0]        over;
    logic [10:0]        under;
    logic [10:0]        start;
    logic [9:0]         first;
    logic [9:0]         delta;
    logic               hit;
    logic [POS_W-1:0]   pos0;
    logic [POS_W-1:0]   pos1;
    logic               keep0;
    logic               keep1;
    logic [BANK_AW-1:0] addr0;
    logic [BANK_AW-1:0] addr1;
    logic [7:0]         mask0;
    logic [7:0]         mask1;
    logic               sel0_e;
    logic               sel1_e;
    logic               sel0_o;
    logic               sel1_o;

    // Start dot and first kept column from the current registers
    always_comb begin
        w      = (logo_columns > 10'(MAX_LOGO_COLUMNS)) ? 10'(MAX_LOGO_COLUMNS) : logo_columns;
        m      = double_width ? {w, 1'b0} : {1'b0, w};
        line_m = 11'(LINE_DOTS);
        over   = m - line_m;
        under  = line_m - m;
        start  = '0;
        first  = '0;
        unique case (align_t'(align_mode))
            ALIGN_MIDDLE: begin
                if (m < line_m) begin
                    start = under >> 1;
                end else begin
                    first = double_width ? 10'(over >> 2) : 10'(over >> 1);
                end
            end
            ALIGN_RIGHT: begin
                if (m < line_m) begin
                    start = under;
                end else begin
                    first = double_width ? 10'(over >> 1) : over[9:0];
                end
            end
            default: begin
                start = '0;
                first = '0;
            end
        endcase
        hit   = (count >= first) && (count < w);
        delta = count - first;
        pos0  = POS_W'(start) + (double_width ? POS_W'({delta, 1'b0}) : POS_W'(delta));
        pos1  = pos0 + POS_W'(1);
        keep0 = hit && (pos0 < POS_W'(LINE_DOTS));
        keep1 = hit && double_width && (pos1 < POS_W'(LINE_DOTS));
    end

    // Even bytes live in one bank, odd bytes in the other
    always_comb begin
        addr0  = BANK_AW'(pos0 >> 4);
        addr1  = BANK_AW'(pos1 >> 4);
        mask0  = 8'h80 >> pos0[2:0];
        mask1  = 8'h80 >> pos1[2:0];
        sel0_e = keep0 && !pos0[3];
        sel1_e = keep1 && !pos1[3];
        sel0_o = keep0 && pos0[3];
        sel1_o = keep1 && pos1[3];

        plan_even.en   = sel0_e || sel1_e;
        plan_even.addr = sel0_e ? addr0 : addr1;
        plan_even.mask = (sel0_e ? mask0 : 8'h00) | (sel1_e ? mask1 : 8'h00);
        plan_odd.en    = sel0_o || sel1_o;
        plan_odd.addr  = sel0_o ? addr0 : addr1;
        plan_odd.mask  = (sel0_o ? mask0 : 8'h00) | (sel1_o ? mask1 : 8'h00);
    end

endmodule

`default_nettype wire

@@ hw/rtl/logo_column_band_rasterizer.sv @@
// Read path: the accepted beat passes the placement stage and the band stage, then the output register sets m_tvalid.
// Throughput: one beat per cycle for any command mix; s_tready drops only while a read
// result holds in the output register and the one behind it is also a read.
// Reset: synchronous, active low; clears the column counter, registers, pipeline and the
// per-word valid bits, so the band reads as all zero at once with no clearing pass.
// A clear command drops the same valid bits when it reaches the band stage.
`default_nettype none

module logo_column_band_rasterizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] column_byte, [10:8] row, [16:11] byte_index
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] read_data
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_wdata
);

    import lcbr_pkg::*;

    // Configuration
    logic [1:0]  align_reg,  align_next;
    logic [9:0]  cols_reg,   cols_next;
    logic        dw_reg,     dw_next;

    // Column counter, advanced in accept order
    logic [COUNT_W-1:0] count_reg, count_next;

    // Stage A: accepted beat, placement math
    logic               a_valid_reg, a_valid_next;
    cmd_t               a_cmd_reg,   a_cmd_next;
    logic [7:0]         a_bits_reg,  a_bits_next;
    logic [2:0]         a_row_reg,   a_row_next;
    logic [5:0]         a_bidx_reg,  a_bidx_next;
    logic [COUNT_W-1:0] a_count_reg, a_count_next;

    // Stage B: band read-modify-write and read select
    logic               b_valid_reg,   b_valid_next;
    cmd_t               b_cmd_reg,     b_cmd_next;
    logic [7:0]         b_bits_reg,    b_bits_next;
    logic [2:0]         b_row_reg,     b_row_next;
    logic               b_sel_reg,     b_sel_next;
    logic               b_inrange_reg, b_inrange_next;
    plan_t              b_plan_reg [BANKS];
    plan_t              b_plan_next [BANKS];

    // Per bank word valid bits and last write for read-during-write bypass
    logic [BANK_DEPTH-1:0] vld_reg [BANKS];
    logic [BANK_DEPTH-1:0] vld_next [BANKS];
    logic                  lw_v_reg [BANKS];
    logic                  lw_v_next [BANKS];
    logic [BANK_AW-1:0]    lw_addr_reg [BANKS];
    logic [BANK_AW-1:0]    lw_addr_next [BANKS];
    logic [WORD_W-1:0]     lw_data_reg [BANKS];
    logic [WORD_W-1:0]     lw_data_next [BANKS];

    // Output register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg,  m_tdata_next;

    // Combinational
    logic               adv;
    logic               acc;
    cmd_t               cmd_in;
    plan_t              place_even;
    plan_t              place_odd;
    logic               a_inrange;
    logic [BANK_AW-1:0] a_rd_addr;
    plan_t              a_plan [BANKS];
    logic [WORD_W-1:0]  rd_data [BANKS];
    logic [WORD_W-1:0]  old_word [BANKS];
    logic [WORD_W-1:0]  or_word [BANKS];
    logic [WORD_W-1:0]  new_word [BANKS];
    logic               wr_en [BANKS];
    logic [WORD_W-1:0]  read_word;
    logic [7:0]         read_byte;
    logic               b_clear;

    // The whole pipeline moves together; only a read waiting on a full output stalls
    assign adv      = !b_valid_reg || (b_cmd_reg != CMD_READ) || !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;
    assign cmd_in   = cmd_t'(s_tuser);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign b_clear  = adv && b_valid_reg && (b_cmd_reg == CMD_CLEAR);

    // Configuration writes; an index past the list is ignored
    always_comb begin
        align_next = align_reg;
        cols_next  = cols_reg;
        dw_next    = dw_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ALIGN_MODE:   align_next = cfg_wdata[1:0];
                REG_LOGO_COLUMNS: cols_next  = cfg_wdata;
                REG_DOUBLE_WIDTH: dw_next    = cfg_wdata[0];
                default:          align_next = align_reg;
            endcase
        end
    end

    // Counter: clear resets it, place advances it and saturates at the top
    always_comb begin
        count_next = count_reg;
        if (acc) begin
            unique case (cmd_in)
                CMD_CLEAR: count_next = '0;
                CMD_PLACE: begin
                    if (count_reg != COUNT_W'(COUNT_MAX)) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                default:   count_next = count_reg;
            endcase
        end
    end

    // Capture the beat into stage A
    always_comb begin
        a_valid_next = a_valid_reg;
        a_cmd_next   = a_cmd_reg;
        a_bits_next  = a_bits_reg;
        a_row_next   = a_row_reg;
        a_bidx_next  = a_bidx_reg;
        a_count_next = a_count_reg;
        if (adv) begin
            a_valid_next = s_tvalid;
            a_cmd_next   = cmd_in;
            a_bits_next  = s_tdata[7:0];
            a_row_next   = s_tdata[10:8];
            a_bidx_next  = s_tdata[16:11];
            a_count_next = count_reg;
        end
    end

    lcbr_place u_place (
        .count        (a_count_reg),
        .align_mode   (align_reg),
        .logo_columns (cols_reg),
        .double_width (dw_reg),
        .plan_even    (place_even),
        .plan_odd     (place_odd)
    );

    // Stage A: pick the band words to fetch, for a place or for a read
    always_comb begin
        a_inrange = int'(a_bidx_reg) < ROW_BYTES;
        a_rd_addr = a_inrange ? BANK_AW'(a_bidx_reg >> 1) : '0;
        for (int i = 0; i < BANKS; i++) begin
            a_plan[i] = '0;
        end
        unique case (a_cmd_reg)
            CMD_PLACE: begin
                a_plan[0] = place_even;
                a_plan[1] = place_odd;
            end
            CMD_READ: begin
                for (int i = 0; i < BANKS; i++) begin
                    a_plan[i].addr = a_rd_addr;
                end
            end
            default: begin
                for (int i = 0; i < BANKS; i++) begin
                    a_plan[i] = '0;
                end
            end
        endcase
    end

    always_comb begin
        b_valid_next   = b_valid_reg;
        b_cmd_next     = b_cmd_reg;
        b_bits_next    = b_bits_reg;
        b_row_next     = b_row_reg;
        b_sel_next     = b_sel_reg;
        b_inrange_next = b_inrange_reg;
        for (int i = 0; i < BANKS; i++) begin
            b_plan_next[i] = b_plan_reg[i];
        end
        if (adv) begin
            b_valid_next   = a_valid_reg;
            b_cmd_next     = a_cmd_reg;
            b_bits_next    = a_bits_reg;
            b_row_next     = a_row_reg;
            b_sel_next     = a_bidx_reg[0];
            b_inrange_next = a_inrange;
            for (int i = 0; i < BANKS; i++) begin
                b_plan_next[i] = a_plan[i];
            end
        end
    end

    // Band banks: word of 8 rows, row r in bits [8r+7:8r]
    for (genvar gi = 0; gi < BANKS; gi++) begin : g_bank
        lcbr_ram #(
            .WIDTH (WORD_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (wr_en[gi]),
            .waddr (b_plan_reg[gi].addr),
            .wdata (new_word[gi]),
            .re    (adv),
            .raddr (a_plan[gi].addr),
            .rdata (rd_data[gi])
        );
    end

    // Stage B: old word (never written reads as zero, bypass the write that raced the
    // fetch), OR in the column dots, write back
    always_comb begin
        for (int i = 0; i < BANKS; i++) begin
            if (!vld_reg[i][b_plan_reg[i].addr]) begin
                old_word[i] = '0;
            end else if (lw_v_reg[i] && (lw_addr_reg[i] == b_plan_reg[i].addr)) begin
                old_word[i] = lw_data_reg[i];
            end else begin
                old_word[i] = rd_data[i];
            end
            for (int r = 0; r < BAND_ROWS; r++) begin
                or_word[i][r*8 +: 8] = b_bits_reg[7-r] ? b_plan_reg[i].mask : 8'h00;
            end
            new_word[i] = old_word[i] | or_word[i];
            wr_en[i]    = adv && b_valid_reg && (b_cmd_reg == CMD_PLACE) && b_plan_reg[i].en;
        end
    end

    always_comb begin
        for (int i = 0; i < BANKS; i++) begin
            vld_next[i]     = vld_reg[i];
            lw_v_next[i]    = lw_v_reg[i];
            lw_addr_next[i] = lw_addr_reg[i];
            lw_data_next[i] = lw_data_reg[i];
            if (b_clear) begin
                vld_next[i]  = '0;
                lw_v_next[i] = 1'b0;
            end else if (wr_en[i]) begin
                vld_next[i][b_plan_reg[i].addr] = 1'b1;
                lw_v_next[i]    = 1'b1;
                lw_addr_next[i] = b_plan_reg[i].addr;
                lw_data_next[i] = new_word[i];
            end
        end
    end

    // Read result: pick bank, then row byte; out of range reads zero
    always_comb begin
        read_word     = b_sel_reg ? old_word[1] : old_word[0];
        read_byte     = b_inrange_reg ? read_word[{b_row_reg, 3'b000} +: 8] : 8'h00;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (adv && b_valid_reg && (b_cmd_reg == CMD_READ)) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = read_byte;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_reg    <= '0;
            cols_reg     <= '0;
            dw_reg       <= 1'b0;
            count_reg    <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < BANKS; i++) begin
                vld_reg[i]  <= '0;
                lw_v_reg[i] <= 1'b0;
            end
        end else begin
            align_reg    <= align_next;
            cols_reg     <= cols_next;
            dw_reg       <= dw_next;
            count_reg    <= count_next;
            a_valid_reg  <= a_valid_next;
            b_valid_reg  <= b_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int i = 0; i < BANKS; i++) begin
                vld_reg[i]  <= vld_next[i];
                lw_v_reg[i] <= lw_v_next[i];
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        a_cmd_reg     <= a_cmd_next;
        a_bits_reg    <= a_bits_next;
        a_row_reg     <= a_row_next;
        a_bidx_reg    <= a_bidx_next;
        a_count_reg   <= a_count_next;
        b_cmd_reg     <= b_cmd_next;
        b_bits_reg    <= b_bits_next;
        b_row_reg     <= b_row_next;
        b_sel_reg     <= b_sel_next;
        b_inrange_reg <= b_inrange_next;
        m_tdata_reg   <= m_tdata_next;
        for (int i = 0; i < BANKS; i++) begin
            b_plan_reg[i]  <= b_plan_next[i];
            lw_addr_reg[i] <= lw_addr_next[i];
            lw_data_reg[i] <= lw_data_next[i];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lcbr_checker.sv @@
`default_nettype none

module lcbr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Two stages sit ahead of the output, so no result beat appears straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid ##1 !m_tvalid)
        else $error("result beat too soon after reset");

    // Empty pipeline takes a beat right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("not ready after reset");

    // With the output register free nothing can stall the input
    a_ready_when_free: assert property (@(posedge aclk)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is free");

endmodule

bind logo_column_band_rasterizer lcbr_checker u_lcbr_checker (.*);

`default_nettype wire

@@ tb/logo_column_band_rasterizer_tb.sv @@
`timescale 1ns / 100ps

import lcbr_pkg::*;

// Tracks the band and column counter as the block should hold them.
// Also keeps the queue of band bytes that read beats still owe.
class band_tracker;
    logic [7:0]  band [BAND_ROWS][ROW_BYTES];
    int unsigned col_count;
    logic [1:0]  align;
    logic [9:0]  logo_cols;
    logic        dbl;
    logic [7:0]  owed_bytes[$];
    int          errors;
    int          places;
    int          reads;
    int          clears;

    function new();
        wipe();
        align     = ALIGN_LEFT;
        logo_cols = '0;
        dbl       = 1'b0;
        errors    = 0;
        places    = 0;
        reads     = 0;
        clears    = 0;
    endfunction

    function void wipe();
        foreach (band[r, b]) band[r][b] = 8'h00;
        col_count = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [9:0] value);
        case (index)
            REG_ALIGN_MODE:   align     = value[1:0];
            REG_LOGO_COLUMNS: logo_cols = value;
            REG_DOUBLE_WIDTH: dbl       = value[0];
            default: ;
        endcase
    endfunction

    // Start dot and first kept column for the current registers.
    function void geometry(output int unsigned start_dot, output int unsigned first_col,
                           output int unsigned width_cols, output int unsigned zoom);
        int unsigned span;
        width_cols = (logo_cols > MAX_LOGO_COLUMNS) ? MAX_LOGO_COLUMNS : logo_cols;
        zoom       = dbl ? 2 : 1;
        span       = width_cols * zoom;
        start_dot  = 0;
        first_col  = 0;
        if (align == ALIGN_MIDDLE) begin
            if (span < LINE_DOTS) start_dot = (LINE_DOTS - span) / 2;
            else first_col = (span - LINE_DOTS) / 2 / zoom;
        end else if (align == ALIGN_RIGHT) begin
            if (span < LINE_DOTS) start_dot = LINE_DOTS - span;
            else first_col = (span - LINE_DOTS) / zoom;
        end
    endfunction

    function void stamp_column(logic [7:0] dots);
        int unsigned start_dot, first_col, width_cols, zoom, pos0, p;
        geometry(start_dot, first_col, width_cols, zoom);
        if (col_count >= first_col && col_count < width_cols) begin
            pos0 = start_dot + (col_count - first_col) * zoom;
            for (int r = 0; r < BAND_ROWS; r++) begin
                if (dots[7 - r]) begin
                    for (int k = 0; k < zoom; k++) begin
                        p = pos0 + k;
                        if (p < LINE_DOTS) band[r][p >> 3] |= 8'h80 >> (p & 7);
                    end
                end
            end
        end
        if (col_count < COUNT_MAX) col_count++;
    endfunction

    function void note_beat(logic [1:0] cmd, logic [7:0] col, logic [2:0] row,
                            logic [5:0] idx);
        case (cmd)
            CMD_CLEAR: begin
                wipe();
                clears++;
            end
            CMD_PLACE: begin
                stamp_column(col);
                places++;
            end
            CMD_READ: begin
                owed_bytes.push_back((idx < ROW_BYTES) ? band[row][idx] : 8'h00);
            end
            default: ;
        endcase
    endfunction

    function void check_byte(logic [7:0] got);
        logic [7:0] want;
        if (owed_bytes.size() == 0) begin
            $display("%0t: read_data with no read pending: expected none, actual %02h",
                     $time, got);
            errors++;
        end else begin
            want = owed_bytes.pop_front();
            reads++;
            if (got !== want) begin
                $display("%0t: read_data mismatch: expected %02h, actual %02h",
                         $time, want, got);
                errors++;
            end
        end
    endfunction
endclass

module logo_column_band_rasterizer_tb;

    // Codes with no name in the package
    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam logic [1:0] ALIGN_MODE_THREE = 2'd3;
    // Total beats after which the random phases stop
    localparam int         BEAT_TARGET      = 1150;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [7:0] column_byte, [10:8] row, [16:11] byte_index
    logic [1:0]  s_tuser   = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] read_data
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_wdata = '0;

    band_tracker sb = new();

    int          burst_left = 0;
    int          beats_sent = 0;
    int          phases     = 0;
    logic [11:0] stall_phase = '0;

    logo_column_band_rasterizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: cycle through always-ready, light stalls, long stalls and coin flips in turn,
    // so back-pressure lands on every stage of the pipe.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[11:10])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= (stall_phase[4:0] < 5'd6);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Sample every handshake with the values that stood before the edge.
    // Inputs are noted before results; a read result never shares an edge with its own beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser, s_tdata[7:0], s_tdata[10:8], s_tdata[16:11]);
            if (m_tvalid && m_tready) sb.check_byte(m_tdata);
        end
    end

    // Present one beat and hold it until the block takes it.
    // Open a new burst when the old one runs out, with a random gap in front of it.
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] col,
                             input logic [2:0] row, input logic [5:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, idx, row, col};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_read(input logic [2:0] row, input logic [5:0] idx);
        send_beat(CMD_READ, 8'($urandom_range(0, 255)), row, idx);
    endtask

    task automatic send_place(input logic [7:0] col);
        send_beat(CMD_PLACE, col, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
    endtask

    // Aim most reads at the bytes the logo can touch; the rest anywhere, a few out of range.
    task automatic send_read_pick();
        int unsigned start_dot, first_col, width_cols, zoom, span, dot;
        int          roll;
        logic [5:0]  idx;
        sb.geometry(start_dot, first_col, width_cols, zoom);
        span = width_cols * zoom;
        roll = $urandom_range(0, 99);
        if (roll < 70 && span > 0) begin
            dot = start_dot + $urandom_range(0, span - 1);
            if (dot >= LINE_DOTS) dot = $urandom_range(0, LINE_DOTS - 1);
            idx = 6'(dot / 8);
        end else if (roll < 95) begin
            idx = 6'($urandom_range(0, ROW_BYTES - 1));
        end else begin
            idx = 6'($urandom_range(ROW_BYTES, 63));
        end
        send_read(3'($urandom_range(0, 7)), idx);
    endtask

    // Drop valid, let the last accepted beat reach the scoreboard, drain every owed
    // read, then give the pipe time to finish any place or clear still in flight
    // (two stages deep).
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.owed_bytes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers on back-to-back edges; the block is idle here.
    task automatic set_config(input logic [1:0] align, input logic [9:0] cols,
                              input logic dbl);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ALIGN_MODE;
        cfg_wdata <= {8'd0, align};
        @(posedge aclk);
        cfg_index <= REG_LOGO_COLUMNS;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_index <= REG_DOUBLE_WIDTH;
        cfg_wdata <= {9'd0, dbl};
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One logo: configure, clear, stream columns with reads, unused codes and optional clears mixed in, then read back.
    task automatic run_phase(input logic [1:0] align, input logic [9:0] cols,
                             input logic dbl, input int n_places, input int read_pct,
                             input bit allow_clear);
        int placed;
        int roll;
        placed = 0;
        settle();
        set_config(align, cols, dbl);
        send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  6'($urandom_range(0, 63)));
        while (placed < n_places) begin
            roll = $urandom_range(0, 99);
            if (roll < read_pct) begin
                send_read_pick();
            end else if (roll < read_pct + 2) begin
                send_beat(CMD_UNUSED, 8'($urandom_range(0, 255)),
                          3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
            end else if (roll < read_pct + 3 && allow_clear) begin
                send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)),
                          3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
            end else begin
                send_place(8'($urandom_range(0, 255)));
                placed++;
            end
        end
        repeat (8) send_read_pick();
        phases++;
    endtask

    // Pick a random geometry: mostly narrow logos, some near the point where
    // the logo just fills the line, a few clamped widths.
    task automatic random_phase();
        int unsigned pick, width, n;
        logic [1:0]  align;
        align = ($urandom_range(0, 9) == 0) ? ALIGN_MODE_THREE : 2'($urandom_range(0, 2));
        pick  = $urandom_range(0, 99);
        if (pick < 60)      width = $urandom_range(1, 48);
        else if (pick < 64) width = 0;
        else if (pick < 80) width = $urandom_range(189, 194);
        else if (pick < 92) width = $urandom_range(380, 388);
        else                width = $urandom_range(577, 1023);
        if (width == 0)        n = $urandom_range(4, 12);
        else if (width <= 200) n = width + $urandom_range(0, 6);
        else                   n = $urandom_range(16, 80);
        run_phase(align, 10'(width), 1'($urandom_range(0, 1)), n, 20, 1'b1);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fresh band reads zero; with zero width a column places nothing.
        send_read(3'd0, 6'd0);
        send_read(3'd7, 6'd47);
        send_place(8'hFF);

        // Widest logo, double width, left: full, top-only, bottom-only and empty columns,
        // then the band edges, out-of-range indexes, the unused code and a clear.
        settle();
        set_config(ALIGN_LEFT, 10'(MAX_LOGO_COLUMNS), 1'b1);
        send_place(8'hFF);
        send_place(8'h80);
        send_place(8'h01);
        send_place(8'h00);
        send_read(3'd0, 6'd0);
        send_read(3'd7, 6'd0);
        send_read(3'd3, 6'd0);
        send_read(3'd0, 6'd47);
        send_read(3'd7, 6'd63);
        send_read(3'd0, 6'd48);
        send_beat(CMD_UNUSED, 8'hAA, 3'd5, 6'd42);
        send_beat(CMD_CLEAR, 8'h55, 3'd2, 6'd21);
        send_read(3'd0, 6'd0);

        // Align code three behaves as left; width above the limit is clamped.
        settle();
        set_config(ALIGN_MODE_THREE, 10'h3FF, 1'b0);
        send_place(8'h5A);
        send_place(8'hA5);
        send_read(3'd1, 6'd0);
        send_read(3'd6, 6'd0);

        // One column right-aligned lands on the last dot of the line.
        settle();
        set_config(ALIGN_RIGHT, 10'd1, 1'b0);
        send_beat(CMD_CLEAR, 8'h00, 3'd0, 6'd0);
        send_place(8'hFF);
        send_read(3'd0, 6'd47);
        send_read(3'd7, 6'd47);

        // Widest doubled logo, left: the line fills, later columns clip past it,
        // surplus columns follow and the counter runs into its top.
        run_phase(ALIGN_LEFT, 10'(MAX_LOGO_COLUMNS), 1'b1, COUNT_MAX + 17, 4, 1'b0);

        while (beats_sent < BEAT_TARGET) random_phase();

        settle();
        if (sb.owed_bytes.size() != 0) begin
            $display("%0t: reads left unanswered: expected 0, actual %0d",
                     $time, sb.owed_bytes.size());
            sb.errors++;
        end
        $display("Ran %0d beats over %0d logo setups: %0d columns placed, %0d clears,",
                 beats_sent, phases, sb.places, sb.clears);
        $display("and %0d band bytes read back and compared (%0d mismatches).",
                 sb.reads, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Run timed out with %0d reads still owed", sb.owed_bytes.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
